// ===== src/sld_pkg.sv =====
`default_nettype none
package sld_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;
  localparam int unsigned CfgIdxW = 3;

  // result kinds
  localparam logic [KindW-1:0] KIND_DATA  = 2'd0;
  localparam logic [KindW-1:0] KIND_GOOD  = 2'd1;
  localparam logic [KindW-1:0] KIND_BAD   = 2'd2;
  localparam logic [KindW-1:0] KIND_IDENT = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SYNC_FIRST  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SYNC_SECOND = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_LENGTH  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_QUERY_BYTE  = 3'd3;

  // configuration reset values
  localparam logic [ByteW-1:0] SYNC_FIRST_RST  = 8'hA5;
  localparam logic [ByteW-1:0] SYNC_SECOND_RST = 8'h5A;
  localparam logic [ByteW-1:0] MAX_LENGTH_RST  = 8'd250;
  localparam logic [ByteW-1:0] QUERY_BYTE_RST  = 8'h3F;

  typedef struct packed {
    logic [ByteW-1:0] sync_first;
    logic [ByteW-1:0] sync_second;
    logic [ByteW-1:0] max_length;
    logic [ByteW-1:0] query_byte;
  } cfg_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] length;
  } result_t;

endpackage
`default_nettype wire

// ===== src/sld_cfg.sv =====
`default_nettype none
module sld_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [sld_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [sld_pkg::ByteW-1:0]   cfg_data,
  output sld_pkg::cfg_t                   cfg
);
  import sld_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // register file write decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_FIRST:  cfg_nxt.sync_first  = cfg_data;
        REG_SYNC_SECOND: cfg_nxt.sync_second = cfg_data;
        REG_MAX_LENGTH:  cfg_nxt.max_length  = cfg_data;
        REG_QUERY_BYTE:  cfg_nxt.query_byte  = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first  <= SYNC_FIRST_RST;
      cfg_r.sync_second <= SYNC_SECOND_RST;
      cfg_r.max_length  <= MAX_LENGTH_RST;
      cfg_r.query_byte  <= QUERY_BYTE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== src/sld_parse.sv =====
`default_nettype none
module sld_parse (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  sld_pkg::cfg_t                 cfg,
  input  wire logic                     item_valid,
  input  wire logic [sld_pkg::ByteW-1:0] item_byte,
  output logic                          item_take,
  output logic                          res_valid,
  input  wire logic                     res_ready,
  output sld_pkg::result_t              res
);
  import sld_pkg::*;

  localparam logic [2:0] PH_SYNC1   = 3'd0;
  localparam logic [2:0] PH_SYNC2   = 3'd1;
  localparam logic [2:0] PH_LENGTH  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CHECK   = 3'd4;

  logic [2:0]       phase_r, phase_nxt;
  logic [ByteW-1:0] len_r, len_nxt;
  logic [ByteW-1:0] cnt_r, cnt_nxt;
  logic [ByteW-1:0] chk_r, chk_nxt;
  logic             res_valid_r, res_valid_nxt;
  result_t          res_r, res_nxt;
  logic             emit;
  result_t          step_res;
  logic [ByteW:0]   cnt_inc;

  // result register frees up when empty or being drained
  assign item_take = item_valid && (!res_valid_r || res_ready);
  assign cnt_inc   = {1'b0, cnt_r} + {{ByteW{1'b0}}, 1'b1};

  // one parse step per byte
  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    chk_nxt   = chk_r;
    emit      = 1'b0;
    step_res  = '0;
    case (phase_r)
      PH_SYNC2: begin
        phase_nxt = (item_byte == cfg.sync_second) ? PH_LENGTH : PH_SYNC1;
      end
      PH_LENGTH: begin
        if (item_byte == '0 || item_byte > cfg.max_length) begin
          phase_nxt = PH_SYNC1;
        end else begin
          len_nxt   = item_byte;
          cnt_nxt   = '0;
          chk_nxt   = item_byte;
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        chk_nxt = chk_r ^ item_byte;
        cnt_nxt = cnt_inc[ByteW-1:0];
        if (cnt_inc >= {1'b0, len_r}) phase_nxt = PH_CHECK;
        emit            = 1'b1;
        step_res.kind   = KIND_DATA;
        step_res.data   = item_byte;
        step_res.length = len_r;
      end
      PH_CHECK: begin
        phase_nxt       = PH_SYNC1;
        emit            = 1'b1;
        step_res.kind   = (chk_r == item_byte) ? KIND_GOOD : KIND_BAD;
        step_res.length = len_r;
      end
      default: begin
        // hunting; query match wins over first sync
        phase_nxt = PH_SYNC1;
        if (item_byte == cfg.query_byte) begin
          emit          = 1'b1;
          step_res.kind = KIND_IDENT;
        end else if (item_byte == cfg.sync_first) begin
          phase_nxt = PH_SYNC2;
        end
      end
    endcase
  end

  // output register
  always_comb begin
    res_valid_nxt = res_valid_r;
    res_nxt       = res_r;
    if (res_ready) res_valid_nxt = 1'b0;
    if (item_take && emit) begin
      res_valid_nxt = 1'b1;
      res_nxt       = step_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SYNC1;
      len_r       <= '0;
      cnt_r       <= '0;
      chk_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (item_take) begin
        phase_r <= phase_nxt;
        len_r   <= len_nxt;
        cnt_r   <= cnt_nxt;
        chk_r   <= chk_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire

// ===== src/sync_length_xor_deframer.sv =====
// Each byte passes the input register and then the result register on its way to a result beat.
// Throughput: one byte per cycle while out_ready does not stall the result register; the parse
// step is a single combinational state update between the two registers.
// Bytes that close no result (sync, length, aborts) give no output beat.
// Reset (rst_n low, synchronous) returns to sync hunting, empties both
// registers and loads the default sync, length limit and query values.
`default_nettype none
module sync_length_xor_deframer (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [sld_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [sld_pkg::ByteW-1:0]   cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [sld_pkg::ByteW-1:0]   in_rx_byte,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [sld_pkg::KindW-1:0]       out_kind,
  output logic [sld_pkg::ByteW-1:0]       out_byte,
  output logic [sld_pkg::ByteW-1:0]       out_frame_length
);
  import sld_pkg::*;

  cfg_t             cfg;
  result_t          res;
  logic             in_valid_r, in_valid_nxt;
  logic [ByteW-1:0] in_byte_r;
  logic             item_take;

  sld_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register
  assign in_ready = !in_valid_r || item_take;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (item_take) in_valid_nxt = 1'b0;
    if (in_valid && in_ready) in_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_byte_r <= in_rx_byte;
  end

  sld_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (in_valid_r),
    .item_byte  (in_byte_r),
    .item_take  (item_take),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  assign out_kind         = res.kind;
  assign out_byte         = res.data;
  assign out_frame_length = res.length;

endmodule
`default_nettype wire

// ===== src/sld_checker.sv =====
`default_nettype none
module sld_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [sld_pkg::KindW-1:0]  out_kind,
  input wire logic [sld_pkg::ByteW-1:0]  out_byte,
  input wire logic [sld_pkg::ByteW-1:0]  out_frame_length
);
  import sld_pkg::*;

  // nothing leaves right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind)
      && $stable(out_byte) && $stable(out_frame_length))
    else $error("stalled result changed");

  // only payload beats carry a byte
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DATA |-> out_byte == '0)
    else $error("nonzero byte on non-payload beat");

  // frame beats carry a nonzero length, identify beats none
  a_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == KIND_IDENT) == (out_frame_length == '0)))
    else $error("frame length inconsistent with kind");

endmodule

bind sync_length_xor_deframer sld_checker u_sld_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_kind         (out_kind),
  .out_byte         (out_byte),
  .out_frame_length (out_frame_length)
);
`default_nettype wire
